// ----- rtl/cbd_pkg.sv -----
// cbd_pkg: shared constants and result type for the chunked body deframer
// no dependencies
`timescale 1ns / 1ps

package cbd_pkg;

  localparam int SIZE_BITS = 31;
  localparam int BYTE_W    = 8;

  // framing status codes
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // line characters
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0a;

  typedef logic [SIZE_BITS-1:0] size_t;

  typedef struct packed {
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic [1:0]        framing_status;
    logic              body_done;
  } result_t;

endpackage

// ----- rtl/cbd_in_if.sv -----
// cbd_in_if: input byte channel of the chunked body deframer
// no dependencies
`timescale 1ns / 1ps

interface cbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       end_of_body;

  modport source(output valid, output body_byte, output end_of_body, input ready);
  modport sink(input valid, input body_byte, input end_of_body, output ready);
endinterface

// ----- rtl/cbd_out_if.sv -----
// cbd_out_if: result channel of the chunked body deframer
// no dependencies
`timescale 1ns / 1ps

interface cbd_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [1:0] framing_status;
  logic       body_done;

  modport source(output valid, output payload_valid, output payload_byte,
                 output framing_status, output body_done, input ready);
  modport sink(input valid, input payload_valid, input payload_byte,
               input framing_status, input body_done, output ready);
endinterface

// ----- rtl/chunked_body_deframer_top.sv -----
// a result is registered and shows in the cycle after its byte is accepted
// throughput: one byte per cycle while results are taken; the framing state updates on each accepted byte
// the result register frees as it is taken, so a stalled sink holds input off
// reset: synchronous active-low rst_n returns the deframer to an empty size
// line and empties the result register
`timescale 1ns / 1ps

module chunked_body_deframer_top (
  input logic       clk,
  input logic       rst_n,
  cbd_in_if.sink    in_ch,
  cbd_out_if.source out_ch
);
  import cbd_pkg::*;

  logic    in_ready;
  logic    accept;
  result_t step_res;
  result_t out_res;

  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  cbd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .body_byte   (in_ch.body_byte),
    .end_of_body (in_ch.end_of_body),
    .res         (step_res)
  );

  cbd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_res    (step_res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.payload_valid  = out_res.payload_valid;
  assign out_ch.payload_byte   = out_res.payload_byte;
  assign out_ch.framing_status = out_res.framing_status;
  assign out_ch.body_done      = out_res.body_done;

endmodule

// ----- rtl/cbd_core.sv -----
// cbd_core: framing state register and per-byte decode of the chunked body
// depends on cbd_pkg
`timescale 1ns / 1ps

module cbd_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [cbd_pkg::BYTE_W-1:0]  body_byte,
  input  logic                        end_of_body,
  output cbd_pkg::result_t            res
);
  import cbd_pkg::*;

  localparam logic [2:0] PH_SIZE = 3'd0;
  localparam logic [2:0] PH_EXT  = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_CR   = 3'd3;
  localparam logic [2:0] PH_LF   = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;
  localparam logic [2:0] PH_BAD  = 3'd6;

  logic [2:0] phase_r, phase_nxt;
  logic       digit_r, digit_nxt;
  size_t      size_r, size_nxt;

  logic       sb_en;
  size_t      sb_size;
  logic       sb_digit;
  logic       hex_ok;
  logic [3:0] hex_val;

  // hex digit decode
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (body_byte >= 8'h30 && body_byte <= 8'h39) begin
      hex_val = 4'(body_byte - 8'h30);
    end else if (body_byte >= 8'h61 && body_byte <= 8'h66) begin
      hex_val = 4'(body_byte - 8'h57);
    end else if (body_byte >= 8'h41 && body_byte <= 8'h46) begin
      hex_val = 4'(body_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    digit_nxt = digit_r;
    size_nxt  = size_r;
    sb_en     = 1'b0;
    sb_size   = size_r;
    sb_digit  = digit_r;
    res.payload_valid = 1'b0;
    res.payload_byte  = '0;

    case (phase_r)
      PH_SIZE: begin
        sb_en = 1'b1;
      end
      PH_EXT: begin
        if (body_byte == CH_LF) begin
          phase_nxt = (size_r == '0) ? PH_DONE : PH_DATA;
          digit_nxt = 1'b0;
        end
      end
      PH_DATA: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = body_byte;
        size_nxt = size_r - size_t'(1);
        if (size_r == size_t'(1)) begin
          phase_nxt = PH_CR;
        end
      end
      PH_CR, PH_LF: begin
        phase_nxt = PH_SIZE;
        digit_nxt = 1'b0;
        size_nxt  = '0;
        sb_size   = '0;
        sb_digit  = 1'b0;
        if (phase_r == PH_CR && body_byte == CH_CR) begin
          phase_nxt = PH_LF;
          size_nxt  = size_r;
        end else if (body_byte != CH_LF) begin
          // a missing line end: this byte opens the next size line
          sb_en = 1'b1;
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_nxt = PH_BAD;
      end
    endcase

    if (sb_en) begin
      if (hex_ok) begin
        if (sb_size[SIZE_BITS-1 -: 4] != 4'd0) begin
          phase_nxt = PH_BAD;
        end else begin
          size_nxt  = {sb_size[SIZE_BITS-5:0], hex_val};
          digit_nxt = 1'b1;
        end
      end else if (!sb_digit) begin
        phase_nxt = PH_BAD;
      end else if (body_byte == CH_LF) begin
        phase_nxt = (sb_size == '0) ? PH_DONE : PH_DATA;
        digit_nxt = 1'b0;
      end else begin
        phase_nxt = PH_EXT;
      end
    end

    if (phase_nxt == PH_DONE) begin
      res.framing_status = ST_DONE;
    end else if (phase_nxt == PH_BAD) begin
      res.framing_status = ST_BAD;
    end else begin
      res.framing_status = ST_BUSY;
    end
    res.body_done = end_of_body;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE;
      digit_r <= 1'b0;
      size_r  <= '0;
    end else if (accept) begin
      if (end_of_body) begin
        phase_r <= PH_SIZE;
        digit_r <= 1'b0;
        size_r  <= '0;
      end else begin
        phase_r <= phase_nxt;
        digit_r <= digit_nxt;
        size_r  <= size_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_eob_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_of_body |=> phase_r == PH_SIZE && size_r == '0 && !digit_r)
    else $error("block did not restart after end of body");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> size_r != '0)
    else $error("payload phase with zero bytes remaining");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !end_of_body && phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("completed body left done phase");
`endif

endmodule

// ----- rtl/cbd_out_stage.sv -----
// cbd_out_stage: result register between decode logic and result channel
// depends on cbd_pkg
`timescale 1ns / 1ps

module cbd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cbd_pkg::result_t in_res,
  output logic             out_valid,
  input  logic             out_ready,
  output cbd_pkg::result_t out_res
);
  import cbd_pkg::*;

  logic    valid_r;
  result_t res_r;

  // a new transfer enters when the slot is empty or drains this cycle
  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_r <= in_res;
    end
  end

`ifndef SYNTHESIS
  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> valid_r)
    else $error("accepted byte produced no result");
`endif

endmodule

// ----- dv/cbd_frame_checker.sv -----
// cbd_frame_checker: watches both channels of the chunked body deframer,
// predicts each result from the accepted bytes and compares it field by field
// depends on cbd_pkg, cbd_in_if and cbd_out_if
`timescale 1ns / 1ps

module cbd_frame_checker (
  input  logic clk,
  input  logic rst_n,
  cbd_in_if    in_mon,
  cbd_out_if   out_mon,
  output int   mismatches,
  output int   pending
);
  import cbd_pkg::*;

  typedef enum logic [2:0] {
    DF_SIZE, DF_EXT, DF_BODY, DF_CR, DF_LF, DF_END, DF_MALFORMED
  } deframe_phase_t;

  deframe_phase_t phase_q;
  logic           digit_seen_q;
  size_t          count_q;
  result_t        due_results[$];
  int             err_count;

  function automatic int hex_nibble(input logic [BYTE_W-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h57);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h37);
    return -1;
  endfunction

  task automatic open_size_line();
    phase_q      = DF_SIZE;
    digit_seen_q = 1'b0;
    count_q      = '0;
  endtask

  task automatic close_size_line();
    phase_q      = (count_q == '0) ? DF_END : DF_BODY;
    digit_seen_q = 1'b0;
  endtask

  task automatic take_size_char(input logic [BYTE_W-1:0] c);
    int v;
    v = hex_nibble(c);
    if (v >= 0) begin
      // one more digit would push the size past the counter width
      if (count_q[SIZE_BITS-1 -: 4] != '0) begin
        phase_q = DF_MALFORMED;
      end else begin
        count_q      = {count_q[SIZE_BITS-5:0], v[3:0]};
        digit_seen_q = 1'b1;
      end
    end else if (!digit_seen_q) begin
      phase_q = DF_MALFORMED;
    end else if (c == CH_LF) begin
      close_size_line();
    end else begin
      phase_q = DF_EXT;
    end
  endtask

  task automatic deframe_byte(input logic [BYTE_W-1:0] c, input logic eob,
                              output result_t r);
    r = '0;
    case (phase_q)
      DF_SIZE: take_size_char(c);
      DF_EXT: begin
        if (c == CH_LF) close_size_line();
      end
      DF_BODY: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = c;
        count_q         = count_q - size_t'(1);
        if (count_q == '0) phase_q = DF_CR;
      end
      DF_CR: begin
        if (c == CH_CR) begin
          phase_q = DF_LF;
        end else begin
          // a missing CR or LF: the byte starts the next size line
          open_size_line();
          if (c != CH_LF) take_size_char(c);
        end
      end
      DF_LF: begin
        open_size_line();
        if (c != CH_LF) take_size_char(c);
      end
      DF_END: ;
      default: phase_q = DF_MALFORMED;
    endcase
    if (phase_q == DF_END) r.framing_status = ST_DONE;
    else if (phase_q == DF_MALFORMED) r.framing_status = ST_BAD;
    else r.framing_status = ST_BUSY;
    r.body_done = eob;
    if (eob) open_size_line();
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      err_count++;
    end
  endtask

  initial err_count = 0;

  always @(posedge clk) begin
    result_t r;
    if (!rst_n) begin
      open_size_line();
      due_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        deframe_byte(in_mon.body_byte, in_mon.end_of_body, r);
        due_results.push_back(r);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h %0h %0h %0h",
                   $time, out_mon.payload_valid, out_mon.payload_byte,
                   out_mon.framing_status, out_mon.body_done);
          err_count++;
        end else begin
          r = due_results.pop_front();
          check_field("payload_valid", int'(r.payload_valid),
                      int'(out_mon.payload_valid));
          check_field("payload_byte", int'(r.payload_byte),
                      int'(out_mon.payload_byte));
          check_field("framing_status", int'(r.framing_status),
                      int'(out_mon.framing_status));
          check_field("body_done", int'(r.body_done), int'(out_mon.body_done));
        end
      end
    end
    mismatches <= err_count;
    pending    <= due_results.size();
  end

endmodule

// ----- dv/tb_chunked_body_deframer_top.sv -----
// tb_chunked_body_deframer_top: drives chunked bodies into the deframer with
// random idling on both sides and gives the verdict
// depends on cbd_pkg, cbd_in_if, cbd_out_if, chunked_body_deframer_top, cbd_frame_checker
`timescale 1ns / 1ps

module tb_chunked_body_deframer_top;
  import cbd_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 2000;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatch_count;
  int   pending_count;
  int   idle_cycles = 0;
  int   useful_sent = 0;
  int   sender_run_left = 0;
  bit   sender_steady = 1'b0;

  logic [BYTE_W-1:0] body_q[$];

  cbd_in_if  in_ch();
  cbd_out_if out_ch();

  chunked_body_deframer_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cbd_frame_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatch_count),
    .pending    (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ends the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      idle_cycles <= 0;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("chunked_body_deframer_top verification failed");
      $finish;
    end
  end

  task automatic push_digit(input logic [3:0] n);
    if (n < 10) body_q.push_back(8'h30 + 8'(n));
    else if ($urandom_range(0, 1)) body_q.push_back(8'h37 + 8'(n));
    else body_q.push_back(8'h57 + 8'(n));
  endtask

  task automatic push_hex(input size_t val, input int lead);
    int ndig;
    ndig = 1;
    for (int i = 1; i < 8; i++) if ((val >> (4 * i)) != 0) ndig = i + 1;
    repeat (lead) body_q.push_back(8'h30);
    for (int i = ndig - 1; i >= 0; i--) push_digit(4'(val >> (4 * i)));
  endtask

  // optional extension, optional CR, then the LF that closes the size line
  task automatic end_size_line();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) begin
      body_q.push_back(8'h3b);
      repeat ($urandom_range(0, 4)) begin
        b = 8'($urandom_range(0, 255));
        body_q.push_back((b == CH_LF) ? 8'h20 : b);
      end
    end
    if ($urandom_range(0, 4) != 0) body_q.push_back(CH_CR);
    body_q.push_back(CH_LF);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eob);
    int gap;
    if (sender_run_left == 0) begin
      sender_run_left = $urandom_range(10, 60);
      sender_steady   = ($urandom_range(0, 3) == 0);
    end
    sender_run_left--;
    gap = sender_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.body_byte   <= b;
    in_ch.end_of_body <= eob;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // bytes from tail_start on follow the terminal chunk and are only ignored
  task automatic send_body(input int tail_start);
    for (int i = 0; i < body_q.size(); i++) begin
      send_byte(body_q[i], i == body_q.size() - 1);
      if (i < tail_start) useful_sent++;
    end
  endtask

  // result side: random stalls, steady stretches and a few long hold-offs
  initial begin
    int  hold;
    int  taken;
    int  run_left;
    bit  steady;
    taken    = 0;
    run_left = 0;
    steady   = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (run_left == 0) begin
        run_left = $urandom_range(10, 60);
        steady   = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      if (taken % 700 == 350) hold = HOLD_CYCLES;
      else hold = steady ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  initial begin
    int         nchunks;
    int         tail_start;
    int         keep;
    size_t      piece_len;
    logic [7:0] b;
    bit         cut;

    in_ch.valid       <= 1'b0;
    in_ch.body_byte   <= '0;
    in_ch.end_of_body <= 1'b0;
    rst_n             <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // one chunk carrying 0xff, the terminal chunk, then an ignored byte
    body_q.delete();
    push_hex(size_t'(1), 0);
    body_q.push_back(CH_CR);
    body_q.push_back(CH_LF);
    body_q.push_back(8'hff);
    body_q.push_back(CH_CR);
    body_q.push_back(CH_LF);
    push_hex(size_t'(0), 0);
    body_q.push_back(CH_CR);
    body_q.push_back(CH_LF);
    body_q.push_back(8'h00);
    send_body(9);

    // size line opening with a non-digit
    body_q.delete();
    body_q.push_back(8'h67);
    body_q.push_back(8'h00);
    send_body(body_q.size());

    // eighth digit overflows the size counter
    body_q.delete();
    body_q.push_back(8'h46);
    repeat (6) body_q.push_back(8'h66);
    body_q.push_back(8'h30);
    send_body(body_q.size());

    // bare LF after the payload, then a size line cut short by end of body
    body_q.delete();
    body_q.push_back(8'h31);
    body_q.push_back(CH_LF);
    body_q.push_back(8'h00);
    body_q.push_back(CH_LF);
    body_q.push_back(8'h30);
    send_body(body_q.size());

    while (useful_sent < ITEM_TARGET) begin
      body_q.delete();
      tail_start = 1 << 30;
      cut        = 1'b0;
      if ($urandom_range(0, 4) != 0) begin
        nchunks = $urandom_range(0, 3);
        for (int k = 0; k < nchunks; k++) begin
          if (!cut) begin
            case ($urandom_range(0, 19))
              0:       piece_len = size_t'($urandom_range(25, 120));
              1:       piece_len = ($urandom_range(0, 3) == 0) ? '1 : size_t'($urandom);
              default: piece_len = size_t'($urandom_range(1, 16));
            endcase
            if (piece_len == '0) piece_len = size_t'(1);
            push_hex(piece_len, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : 0);
            end_size_line();
            if (piece_len > 200) begin
              // huge chunk: a few payload bytes and the body ends
              repeat ($urandom_range(1, 6)) body_q.push_back(8'($urandom_range(0, 255)));
              cut = 1'b1;
            end else begin
              repeat (piece_len) body_q.push_back(8'($urandom_range(0, 255)));
              case ($urandom_range(0, 9))
                7: body_q.push_back(CH_LF);
                8: body_q.push_back(CH_CR);
                9: ;
                default: begin
                  body_q.push_back(CH_CR);
                  body_q.push_back(CH_LF);
                end
              endcase
            end
          end
        end
        if (!cut) begin
          push_hex(size_t'(0), ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0);
          end_size_line();
          tail_start = body_q.size();
          repeat ($urandom_range(0, 2)) body_q.push_back(8'($urandom_range(0, 255)));
        end
      end else begin
        case ($urandom_range(0, 2))
          0: repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom_range(0, 255)));
          1: begin
            b = 8'($urandom_range(0, 255));
            if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                (b >= 8'h61 && b <= 8'h66)) b = 8'h3b;
            body_q.push_back(b);
            repeat ($urandom_range(0, 3)) body_q.push_back(8'($urandom_range(0, 255)));
          end
          default: begin
            // eight to ten digits: some overflow, some only just fit
            repeat ($urandom_range(0, 3)) body_q.push_back(8'h30);
            push_digit(4'($urandom_range(1, 15)));
            repeat ($urandom_range(7, 9)) push_digit(4'($urandom_range(0, 15)));
            body_q.push_back(CH_CR);
            body_q.push_back(CH_LF);
            repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom_range(0, 255)));
          end
        endcase
      end
      if (body_q.size() > 1 && $urandom_range(0, 7) == 0) begin
        keep = $urandom_range(1, body_q.size() - 1);
        while (body_q.size() > keep) void'(body_q.pop_back());
      end
      send_body(tail_start);
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_count != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_count);
    end
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("chunked_body_deframer_top verification clean");
    end else begin
      $display("chunked_body_deframer_top verification failed");
    end
    $finish;
  end

endmodule
